FILE: design/msp_pkg.sv
// Shared constants, types and helpers of the matrix saddle point search.
`default_nettype none

package msp_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;

  localparam int ROW_IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int IDX_W  = (ROW_IW > COL_IW) ? ROW_IW : COL_IW;
  localparam int ADDR_W = ROW_IW + COL_IW;

  localparam int DATA_W = 32;
  localparam int DIM_W  = 5;
  localparam int POS_W  = 4;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  typedef enum logic [1:0] {
    PH_LOAD,
    PH_ROWMIN,
    PH_COLMAX
  } phase_t;

  typedef struct packed {
    logic [ROW_IW-1:0] rows_m1;
    logic [COL_IW-1:0] cols_m1;
    logic              restart;
  } dims_t;

  // Last usable index for a dimension register: zero reads as one, and
  // anything above the limit reads as the limit.
  function automatic logic [IDX_W-1:0] last_index(logic [DIM_W-1:0] v, int unsigned limit);
    logic [IDX_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (int'(v) > int'(limit)) begin
      res = IDX_W'(limit - 1);
    end else begin
      res = IDX_W'(v - DIM_W'(1));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: design/msp_ram.sv
// Matrix store: one write port, one read port with registered read data.
`default_nettype none

module msp_ram
  import msp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: design/msp_cfg.sv
// APB register file holding the row and column counts.
`default_nettype none

module msp_cfg
  import msp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output dims_t                  dims
);

  logic [DIM_W-1:0] row_count_r;
  logic [DIM_W-1:0] col_count_r;
  logic             wr_acc;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign wr_acc  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= DIM_RESET;
      col_count_r <= DIM_RESET;
    end else if (wr_acc) begin
      unique case (reg_sel)
        REG_ROW_COUNT: row_count_r <= pwdata[DIM_W-1:0];
        REG_COL_COUNT: col_count_r <= pwdata[DIM_W-1:0];
        default:       row_count_r <= row_count_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ROW_COUNT: prdata = APB_DW'(row_count_r);
      REG_COL_COUNT: prdata = APB_DW'(col_count_r);
      default:       prdata = '0;
    endcase
  end

  always_comb begin
    dims.rows_m1 = ROW_IW'(last_index(row_count_r, MAX_ROWS));
    dims.cols_m1 = COL_IW'(last_index(col_count_r, MAX_COLS));
    // Any register write drops a partly loaded matrix.
    dims.restart = wr_acc;
  end

endmodule

`default_nettype wire

FILE: design/msp_search.sv
// Load sequencer and row-minimum / column-maximum search over the store.
`default_nettype none

module msp_search
  import msp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dims_t             dims,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [DATA_W-1:0] in_element_value,
  output logic                   ram_wr_en,
  output logic      [ADDR_W-1:0] ram_wr_addr,
  output logic      [DATA_W-1:0] ram_wr_data,
  output logic                   ram_rd_en,
  output logic      [ADDR_W-1:0] ram_rd_addr,
  input  wire logic [DATA_W-1:0] ram_rd_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_found,
  output logic      [DATA_W-1:0] out_point_value,
  output logic      [POS_W-1:0]  out_point_row,
  output logic      [POS_W-1:0]  out_point_col
);

  phase_t state_r, state_nxt;

  logic [ROW_IW-1:0] ld_row_r, ld_row_nxt;
  logic [COL_IW-1:0] ld_col_r, ld_col_nxt;
  logic [ROW_IW-1:0] scan_row_r, scan_row_nxt;
  logic [IDX_W-1:0]  iss_idx_r, iss_idx_nxt;
  logic              iss_done_r, iss_done_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              rd_last_r, rd_last_nxt;
  logic [DATA_W-1:0] min_r, min_nxt;
  logic [COL_IW-1:0] min_col_r, min_col_nxt;
  logic              still_max_r, still_max_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;
  logic [POS_W-1:0]  out_row_r, out_row_nxt;
  logic [POS_W-1:0]  out_col_r, out_col_nxt;

  logic in_acc;
  logic ld_last;
  logic issuing;
  logic iss_last;
  logic rd_less;
  logic rd_greater;
  logic pass_done;
  logic found_now;
  logic last_row;

  assign in_acc     = in_valid && !in_stall;
  assign ld_last    = (ld_row_r == dims.rows_m1) && (ld_col_r == dims.cols_m1);
  assign issuing    = (state_r != PH_LOAD) && !iss_done_r;
  assign iss_last   = (state_r == PH_ROWMIN) ? (iss_idx_r == IDX_W'(dims.cols_m1))
                                             : (iss_idx_r == IDX_W'(dims.rows_m1));
  assign rd_less    = $signed(ram_rd_data) < $signed(min_r);
  assign rd_greater = $signed(ram_rd_data) > $signed(min_r);
  assign pass_done  = rd_vld_r && rd_last_r;
  assign found_now  = still_max_r && !rd_greater;
  assign last_row   = (scan_row_r == dims.rows_m1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      PH_LOAD: begin
        if (in_acc && ld_last) begin
          state_nxt = PH_ROWMIN;
        end
      end
      PH_ROWMIN: begin
        if (pass_done) begin
          state_nxt = PH_COLMAX;
        end
      end
      PH_COLMAX: begin
        if (pass_done) begin
          state_nxt = (found_now || last_row) ? PH_LOAD : PH_ROWMIN;
        end
      end
      default: state_nxt = PH_LOAD;
    endcase
  end

  // Handshake and store access.
  always_comb begin
    // Hold the completing word while the previous result is still unread.
    in_stall    = (state_r != PH_LOAD) || (out_valid_r && ld_last);
    ram_wr_en   = in_acc;
    ram_wr_addr = {ld_row_r, ld_col_r};
    ram_wr_data = in_element_value;
    ram_rd_en   = issuing;
    if (state_r == PH_COLMAX) begin
      ram_rd_addr = {iss_idx_r[ROW_IW-1:0], min_col_r};
    end else begin
      ram_rd_addr = {scan_row_r, iss_idx_r[COL_IW-1:0]};
    end
  end

  // Datapath.
  always_comb begin
    ld_row_nxt    = ld_row_r;
    ld_col_nxt    = ld_col_r;
    scan_row_nxt  = scan_row_r;
    iss_idx_nxt   = iss_idx_r;
    iss_done_nxt  = iss_done_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    rd_last_nxt   = rd_last_r;
    min_nxt       = min_r;
    min_col_nxt   = min_col_r;
    still_max_nxt = still_max_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_value_nxt = out_value_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;

    if (dims.restart) begin
      ld_row_nxt = '0;
      ld_col_nxt = '0;
    end else if (in_acc) begin
      if (ld_col_r == dims.cols_m1) begin
        ld_col_nxt = '0;
        ld_row_nxt = ld_last ? '0 : ld_row_r + ROW_IW'(1);
      end else begin
        ld_col_nxt = ld_col_r + COL_IW'(1);
      end
    end

    if (state_r == PH_LOAD && in_acc && ld_last) begin
      scan_row_nxt = '0;
      iss_idx_nxt  = '0;
      iss_done_nxt = 1'b0;
    end

    if (issuing) begin
      rd_vld_nxt  = 1'b1;
      rd_idx_nxt  = iss_idx_r;
      rd_last_nxt = iss_last;
      if (iss_last) begin
        iss_done_nxt = 1'b1;
      end else begin
        iss_idx_nxt = iss_idx_r + IDX_W'(1);
      end
    end

    if (rd_vld_r && state_r == PH_ROWMIN) begin
      // Strict compare keeps the leftmost minimum.
      if (rd_idx_r == '0 || rd_less) begin
        min_nxt     = ram_rd_data;
        min_col_nxt = rd_idx_r[COL_IW-1:0];
      end
      if (rd_last_r) begin
        still_max_nxt = 1'b1;
        iss_idx_nxt   = '0;
        iss_done_nxt  = 1'b0;
      end
    end

    if (rd_vld_r && state_r == PH_COLMAX) begin
      still_max_nxt = found_now;
      if (rd_last_r) begin
        if (found_now) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_value_nxt = min_r;
          out_row_nxt   = POS_W'(scan_row_r);
          out_col_nxt   = POS_W'(min_col_r);
        end else if (last_row) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_value_nxt = '0;
          out_row_nxt   = '0;
          out_col_nxt   = '0;
        end else begin
          scan_row_nxt = scan_row_r + ROW_IW'(1);
          iss_idx_nxt  = '0;
          iss_done_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PH_LOAD;
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      scan_row_r  <= '0;
      iss_idx_r   <= '0;
      iss_done_r  <= 1'b1;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ld_row_r    <= ld_row_nxt;
      ld_col_r    <= ld_col_nxt;
      scan_row_r  <= scan_row_nxt;
      iss_idx_r   <= iss_idx_nxt;
      iss_done_r  <= iss_done_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    rd_last_r   <= rd_last_nxt;
    min_r       <= min_nxt;
    min_col_r   <= min_col_nxt;
    still_max_r <= still_max_nxt;
    out_found_r <= out_found_nxt;
    out_value_r <= out_value_nxt;
    out_row_r   <= out_row_nxt;
    out_col_r   <= out_col_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_point_value = out_value_r;
  assign out_point_row   = out_row_r;
  assign out_point_col   = out_col_r;

`ifndef SYNTHESIS
  a_wr_only_loading: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> state_r == PH_LOAD)
    else $error("store written during search");

  a_rd_only_search: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> state_r != PH_LOAD)
    else $error("read data returned outside search");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |->
      (out_value_r == '0 && out_row_r == '0 && out_col_r == '0))
    else $error("not-found result carries non-zero fields");

  a_result_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ld_last) |-> !out_valid_r)
    else $error("matrix completed while previous result unread");

  a_search_ends_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == PH_COLMAX && pass_done && (found_now || last_row)) |=> out_valid_r)
    else $error("search ended without a result");
`endif

endmodule

`default_nettype wire

FILE: design/matrix_saddle_point_search.sv
// Top level of the matrix saddle point search.
// Elements arrive one word per cycle while in_stall is low, in row-major
// order, and are written straight into a 16x16 single-read-port store. The
// word that completes the row_count x col_count matrix starts the search:
// for each row the store is read along the row for its leftmost minimum,
// then down that column to check no element is greater; all reads go through
// the one store read port, whose read data is registered. Input is stalled
// during the search, and the completing word of the next matrix is also held
// while a result waits to be taken. A write to either count register
// restarts loading at element zero. Counts of zero read as one and counts
// above 16 read as 16.
`default_nettype none

module matrix_saddle_point_search
  import msp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [DATA_W-1:0] in_element_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_found,
  output logic      [DATA_W-1:0] out_point_value,
  output logic      [POS_W-1:0]  out_point_row,
  output logic      [POS_W-1:0]  out_point_col
);

  dims_t             dims;
  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [DATA_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [DATA_W-1:0] ram_rd_data;

  msp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dims    (dims)
  );

  msp_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  msp_search u_search (
    .clk              (clk),
    .rst_n            (rst_n),
    .dims             (dims),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element_value (in_element_value),
    .ram_wr_en        (ram_wr_en),
    .ram_wr_addr      (ram_wr_addr),
    .ram_wr_data      (ram_wr_data),
    .ram_rd_en        (ram_rd_en),
    .ram_rd_addr      (ram_rd_addr),
    .ram_rd_data      (ram_rd_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_point_value  (out_point_value),
    .out_point_row    (out_point_row),
    .out_point_col    (out_point_col)
  );

endmodule

`default_nettype wire
